[src/dtpc_pkg.sv]
// Package for the depth map back-projection block.
// Field widths, register indexes, reset values and queue depths.
// No dependencies.
package dtpc_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int DEPTH_W  = 24;
   localparam int POINT_W  = 32;
   localparam int SIZE_W   = 13;
   localparam int CENTER_W = 16;
   localparam int RECIP_W  = 32;
   localparam int HALF_W   = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 8;

   localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
   localparam logic [RECIP_W-1:0]  RST_RECIP_X      = 32'd7158278;
   localparam logic [RECIP_W-1:0]  RST_RECIP_Y      = 32'd7158278;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_CENTER_X      = 3'd2,
      CSR_CENTER_Y      = 3'd3,
      CSR_RECIP_FOCAL_X = 3'd4,
      CSR_RECIP_FOCAL_Y = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   image_width;
      logic [SIZE_W-1:0]   image_height;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [RECIP_W-1:0]  recip_focal_x;
      logic [RECIP_W-1:0]  recip_focal_y;
   } cfg_type;

endpackage

[src/dtpc_fifo.sv]
// Small register-based item queue, first in first out.
// Depends on nothing; used between front and back and at the result side.
module dtpc_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [W-1:0]               push_data,
   input  logic                       pop,
   output logic [W-1:0]               pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = AW + 1;

   logic [W-1:0]    mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   always_comb begin
      full     = (count_ff == CNTW'(DEPTH));
      empty    = (count_ff == '0);
      count    = count_ff;
      pop_data = mem_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CNTW'(do_push) - CNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/dtpc_csr.sv]
// Configuration registers of the back-projection block.
// Depends on dtpc_pkg.
module dtpc_csr import dtpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      csr_ready = 1'b1;
      cfg       = cfg_ff;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata[SIZE_W-1:0];
            CSR_CENTER_X:      cfg_in.center_x      = csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y:      cfg_in.center_y      = csr_wdata[CENTER_W-1:0];
            CSR_RECIP_FOCAL_X: cfg_in.recip_focal_x = csr_wdata[RECIP_W-1:0];
            CSR_RECIP_FOCAL_Y: cfg_in.recip_focal_y = csr_wdata[RECIP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.image_height  <= RST_IMAGE_HEIGHT;
         cfg_ff.center_x      <= RST_CENTER_X;
         cfg_ff.center_y      <= RST_CENTER_Y;
         cfg_ff.recip_focal_x <= RST_RECIP_X;
         cfg_ff.recip_focal_y <= RST_RECIP_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/dtpc_front.sv]
// Front end: accepts depth items, tracks raster position, forms pixel offsets.
// Depends on dtpc_pkg; feeds the middle queue.
module dtpc_front import dtpc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAG_W      = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_push,
   input  logic [DEPTH_W-1:0]         req_depth_z,
   input  logic                       mid_full,
   output logic                       mid_push,
   output logic [2*MAG_W+DEPTH_W+2:0] mid_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CH   = $clog2(MAX_HEIGHT);
   localparam int SZX  = ((CW + 1) > SIZE_W) ? (CW + 1) : SIZE_W;
   localparam int SZY  = ((CH + 1) > SIZE_W) ? (CH + 1) : SIZE_W;
   localparam int DW   = MAG_W + 1;

   logic [CW-1:0]    col_ff, col_in;
   logic [CH-1:0]    row_ff, row_in;
   logic             accept;
   logic [SZX-1:0]   w_raw, w_lim;
   logic [SZY-1:0]   h_raw, h_lim;
   logic [CW:0]      col_inc;
   logic [CH:0]      row_inc;
   logic             row_end, last_row, fend;
   logic [DW-1:0]    diff_x, diff_y;
   logic             neg_x, neg_y;
   logic [MAG_W-1:0] mag_x, mag_y;

   always_comb begin
      accept  = req_push && !mid_full;
      w_raw   = SZX'(cfg.image_width);
      h_raw   = SZY'(cfg.image_height);
      if (w_raw == '0) begin
         w_lim = SZX'(1);
      end else if (w_raw > SZX'(MAX_WIDTH)) begin
         w_lim = SZX'(MAX_WIDTH);
      end else begin
         w_lim = w_raw;
      end
      if (h_raw == '0) begin
         h_lim = SZY'(1);
      end else if (h_raw > SZY'(MAX_HEIGHT)) begin
         h_lim = SZY'(MAX_HEIGHT);
      end else begin
         h_lim = h_raw;
      end
      col_inc  = {1'b0, col_ff} + (CW + 1)'(1);
      row_inc  = {1'b0, row_ff} + (CH + 1)'(1);
      row_end  = SZX'(col_inc) >= w_lim;
      last_row = SZY'(row_inc) >= h_lim;
      fend     = row_end && last_row;

      // Q.4 pixel offsets from the principal point, as sign and magnitude
      diff_x = DW'({col_ff, 4'b0000}) - DW'(cfg.center_x);
      diff_y = DW'({row_ff, 4'b0000}) - DW'(cfg.center_y);
      neg_x  = diff_x[DW-1];
      neg_y  = diff_y[DW-1];
      mag_x  = neg_x ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
      mag_y  = neg_y ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];

      mid_push = accept;
      mid_data = {fend, req_depth_z, neg_y, mag_y, neg_x, mag_x};

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_inc[CH-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

`ifndef SYNTHESIS
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && fend |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap after frame end");
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      accept && !row_end |=> col_ff == $past(col_inc[CW-1:0]) && row_ff == $past(row_ff))
      else $error("column counter did not advance");
`endif

endmodule

[src/dtpc_back.sv]
// Back end: projection pipeline (multiply, reciprocal scale, round, saturate)
// and result queue. Depends on dtpc_pkg and dtpc_fifo.
module dtpc_back import dtpc_pkg::*; #(
   parameter int MAG_W = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       mid_empty,
   input  logic [2*MAG_W+DEPTH_W+2:0] mid_data,
   output logic                       mid_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [POINT_W-1:0]         rsp_point_x,
   output logic [POINT_W-1:0]         rsp_point_y,
   output logic [DEPTH_W-1:0]         rsp_point_z,
   output logic                       rsp_frame_end
);

   localparam int PW   = MAG_W + DEPTH_W;
   localparam int AW   = PW + HALF_W;
   localparam int SW   = AW + 1;
   localparam int QW   = SW - 20;
   localparam int OCW  = $clog2(OUT_DEPTH) + 2;
   localparam int RW   = 2*POINT_W + DEPTH_W + 1;
   localparam logic [SW-1:0] ROUND = SW'(64'd1 << 19);

   logic [MAG_W-1:0]   in_mag_x, in_mag_y;
   logic               in_neg_x, in_neg_y, in_fend;
   logic [DEPTH_W-1:0] in_z;

   logic               v1_ff, v2_ff, v3_ff;
   logic               neg_x1_ff, neg_y1_ff, fend1_ff;
   logic               neg_x2_ff, neg_y2_ff, fend2_ff;
   logic               neg_x3_ff, neg_y3_ff, fend3_ff;
   logic [DEPTH_W-1:0] z1_ff, z2_ff, z3_ff;
   logic [PW-1:0]      m_x1_ff, m_y1_ff;
   logic [AW-1:0]      a_x2_ff, b_x2_ff, a_y2_ff, b_y2_ff;
   logic [SW-1:0]      s_x3_ff, s_y3_ff;

   logic [QW-1:0]      q_x, q_y;
   logic [POINT_W-1:0] px, py;
   logic [OCW-1:0]     occ;
   logic               out_full;
   logic [$clog2(OUT_DEPTH):0] out_count;
   logic [RW-1:0]      out_rd;

   function automatic logic [POINT_W-1:0] saturate(input logic [QW-1:0] q, input logic neg);
      logic over;
      over = |q[QW-1:POINT_W-1];
      if (neg) begin
         saturate = over ? {1'b1, {(POINT_W-1){1'b0}}} : POINT_W'(0) - q[POINT_W-1:0];
      end else begin
         saturate = over ? {1'b0, {(POINT_W-1){1'b1}}} : q[POINT_W-1:0];
      end
   endfunction

   always_comb begin
      {in_fend, in_z, in_neg_y, in_mag_y, in_neg_x, in_mag_x} = mid_data;
      // reserve result queue room for everything in flight
      occ = OCW'(out_count) + OCW'(v1_ff) + OCW'(v2_ff) + OCW'(v3_ff);
      mid_pop = !mid_empty && (occ < OCW'(OUT_DEPTH));
      q_x = s_x3_ff[SW-1:20];
      q_y = s_y3_ff[SW-1:20];
      px  = saturate(q_x, neg_x3_ff);
      py  = saturate(q_y, neg_y3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= mid_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_x1_ff   <= PW'(in_mag_x) * PW'(in_z);
      m_y1_ff   <= PW'(in_mag_y) * PW'(in_z);
      neg_x1_ff <= in_neg_x;
      neg_y1_ff <= in_neg_y;
      fend1_ff  <= in_fend;
      z1_ff     <= in_z;

      a_x2_ff   <= AW'(m_x1_ff) * AW'(cfg.recip_focal_x[RECIP_W-1:HALF_W]);
      b_x2_ff   <= AW'(m_x1_ff) * AW'(cfg.recip_focal_x[HALF_W-1:0]);
      a_y2_ff   <= AW'(m_y1_ff) * AW'(cfg.recip_focal_y[RECIP_W-1:HALF_W]);
      b_y2_ff   <= AW'(m_y1_ff) * AW'(cfg.recip_focal_y[HALF_W-1:0]);
      neg_x2_ff <= neg_x1_ff;
      neg_y2_ff <= neg_y1_ff;
      fend2_ff  <= fend1_ff;
      z2_ff     <= z1_ff;

      // (m*rcp + 2^35) >> 36, with the 2^35 folded into the high partial sum
      s_x3_ff   <= SW'(a_x2_ff) + SW'(b_x2_ff[AW-1:HALF_W]) + ROUND;
      s_y3_ff   <= SW'(a_y2_ff) + SW'(b_y2_ff[AW-1:HALF_W]) + ROUND;
      neg_x3_ff <= neg_x2_ff;
      neg_y3_ff <= neg_y2_ff;
      fend3_ff  <= fend2_ff;
      z3_ff     <= z2_ff;
   end

   dtpc_fifo #(
      .W     (RW),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (v3_ff),
      .push_data ({fend3_ff, z3_ff, py, px}),
      .pop       (rsp_pop),
      .pop_data  (out_rd),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign {rsp_frame_end, rsp_point_z, rsp_point_y, rsp_point_x} = out_rd;

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> !out_full)
      else $error("result queue overrun");
   a_pos_sign: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !neg_x3_ff |-> !px[POINT_W-1])
      else $error("positive x wrapped negative");
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      v3_ff && z3_ff == '0 |-> px == '0 && py == '0)
      else $error("zero depth gave nonzero point");
`endif

endmodule

[src/depth_to_point_cloud.sv]
// Depth map to point cloud back-projection, top level.
// Depends on dtpc_pkg, dtpc_csr, dtpc_front, dtpc_fifo, dtpc_back.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------
//   req     | req_push / req_full            | one depth item
//   rsp     | rsp_pop / rsp_empty            | one point item (x, y, z, end)
//   csr     | csr_valid / csr_ready          | one register write
//
// One item per cycle sustained while rsp_pop keeps up; the limit is the
// 8-entry result queue against the 3 projection stages in flight.
// Items pass the middle queue, then multiply, scale and round registers.
// Reset is synchronous: counters and queues clear, registers load defaults.
// req_full rises when the 4-entry middle queue fills; the back end stalls
// only for lack of result queue room, so each side stalls on its own.
module depth_to_point_cloud import dtpc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [DEPTH_W-1:0]         req_depth_z,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [POINT_W-1:0]  rsp_point_x,
   output logic signed [POINT_W-1:0]  rsp_point_y,
   output logic [DEPTH_W-1:0]         rsp_point_z,
   output logic                       rsp_frame_end,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CH    = $clog2(MAX_HEIGHT);
   localparam int MW0   = ((CW + 4) > CENTER_W) ? (CW + 4) : CENTER_W;
   localparam int MAG_W = ((CH + 4) > MW0) ? (CH + 4) : MW0;
   localparam int EW    = 2*MAG_W + DEPTH_W + 3;

   cfg_type                     cfg;
   logic                        mid_push, mid_pop, mid_full, mid_empty;
   logic [EW-1:0]               mid_wr, mid_rd;
   logic [$clog2(MID_DEPTH):0]  mid_count;
   logic [POINT_W-1:0]          point_x, point_y;

   dtpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dtpc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAG_W      (MAG_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_push    (req_push),
      .req_depth_z (req_depth_z),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_data    (mid_wr)
   );

   dtpc_fifo #(
      .W     (EW),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr),
      .pop       (mid_pop),
      .pop_data  (mid_rd),
      .full      (mid_full),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   dtpc_back #(
      .MAG_W (MAG_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .mid_empty     (mid_empty),
      .mid_data      (mid_rd),
      .mid_pop       (mid_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_point_x   (point_x),
      .rsp_point_y   (point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_frame_end (rsp_frame_end)
   );

   assign req_full    = mid_full || (mid_count == ($clog2(MID_DEPTH) + 1)'(MID_DEPTH));
   assign rsp_point_x = point_x;
   assign rsp_point_y = point_y;

endmodule

[dv/depth_to_point_cloud_tb.sv]
// Testbench for depth_to_point_cloud: back-projects random depth streams
// under changing camera setups and checks every point against a scoreboard.
// Depends on dtpc_pkg and the depth_to_point_cloud RTL.
`timescale 1ns / 1ps

module depth_to_point_cloud_tb;
   import dtpc_pkg::*;

   localparam int RANDOM_ITEMS = 1925;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_CAP   = 100;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [POINT_W-1:0] x;
      logic signed [POINT_W-1:0] y;
      logic [DEPTH_W-1:0]        z;
      logic                      frame_end;
   } point_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } reg_write_type;

   class point_scoreboard;
      logic [SIZE_W-1:0]   width_reg;
      logic [SIZE_W-1:0]   height_reg;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [RECIP_W-1:0]  recip_x;
      logic [RECIP_W-1:0]  recip_y;
      logic [11:0]         col_count;
      logic [11:0]         row_count;
      point_type           expected[$];
      int                  errors;

      function new();
         width_reg  = RST_IMAGE_WIDTH;
         height_reg = RST_IMAGE_HEIGHT;
         center_x   = RST_CENTER_X;
         center_y   = RST_CENTER_Y;
         recip_x    = RST_RECIP_X;
         recip_y    = RST_RECIP_Y;
         col_count  = '0;
         row_count  = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_IMAGE_WIDTH:   width_reg  = data[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:  height_reg = data[SIZE_W-1:0];
            CSR_CENTER_X:      center_x   = data[CENTER_W-1:0];
            CSR_CENTER_Y:      center_y   = data[CENTER_W-1:0];
            CSR_RECIP_FOCAL_X: recip_x    = data[RECIP_W-1:0];
            CSR_RECIP_FOCAL_Y: recip_y    = data[RECIP_W-1:0];
            default: ;
         endcase
      endfunction

      // (|offset| * z * rcp + 2^35) >> 36, sign applied after, saturated
      function logic signed [POINT_W-1:0] back_project(logic [DEPTH_W-1:0] z,
         logic [11:0] pos, logic [CENTER_W-1:0] ctr, logic [RECIP_W-1:0] rcp);
         logic signed [31:0] offset;
         logic [16:0]        mag;
         logic [79:0]        scaled;
         logic [43:0]        q;
         offset = $signed({16'd0, pos, 4'd0}) - $signed({16'd0, ctr});
         mag    = (offset < 0) ? 17'(-offset) : 17'(offset);
         scaled = 80'(mag) * 80'(z) * 80'(rcp) + (80'd1 << 35);
         q      = scaled[79:36];
         if (offset < 0) begin
            if (q >= 44'h8000_0000) return 32'h8000_0000;
            return 32'h0 - q[31:0];
         end
         if (q > 44'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return q[31:0];
      endfunction

      function void note_depth(logic [DEPTH_W-1:0] z);
         int        w;
         int        h;
         logic      row_end;
         logic      last_row;
         point_type p;
         w = (width_reg == 0) ? 1 :
             (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
         h = (height_reg == 0) ? 1 :
             (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
         row_end  = (int'(col_count) + 1 >= w);
         last_row = (int'(row_count) + 1 >= h);
         p.x = '0;
         p.y = '0;
         if (z != 0) begin
            p.x = back_project(z, col_count, center_x, recip_x);
            p.y = back_project(z, row_count, center_y, recip_y);
         end
         p.z         = z;
         p.frame_end = row_end && last_row;
         expected.push_back(p);
         if (row_end) begin
            col_count = '0;
            row_count = last_row ? 12'd0 : row_count + 12'd1;
         end else begin
            col_count = col_count + 12'd1;
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= REPORT_CAP) $display("%0t ns mismatch: %s", $time, what);
      endtask

      task check_point(logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] y,
         logic [DEPTH_W-1:0] z, logic fe);
         point_type p;
         if (expected.size() == 0) begin
            report($sformatf("point with nothing outstanding, z=%h", z));
            return;
         end
         p = expected.pop_front();
         if (x !== p.x) report($sformatf("point_x %h, want %h (z=%h)", x, p.x, p.z));
         if (y !== p.y) report($sformatf("point_y %h, want %h (z=%h)", y, p.y, p.z));
         if (z !== p.z) report($sformatf("point_z %h, want %h", z, p.z));
         if (fe !== p.frame_end)
            report($sformatf("frame_end %b, want %b (z=%h)", fe, p.frame_end, p.z));
      endtask
   endclass

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_push    = 1'b0;
   logic [DEPTH_W-1:0]         req_depth_z = '0;
   logic                       rsp_pop     = 1'b0;
   logic                       csr_valid   = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index   = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata   = '0;
   logic                       req_full;
   logic                       rsp_empty;
   logic signed [POINT_W-1:0]  rsp_point_x;
   logic signed [POINT_W-1:0]  rsp_point_y;
   logic [DEPTH_W-1:0]         rsp_point_z;
   logic                       rsp_frame_end;
   logic                       csr_ready;

   point_scoreboard sb;
   reg_write_type   reg_writes[$];
   int              req_calm = 0;
   int              rsp_calm = 0;

   always #2 clock = ~clock;

   depth_to_point_cloud dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_depth_z   (req_depth_z),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // gap before the next item; occasional stretches run with no gaps at all
   function automatic int idle_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [DEPTH_W-1:0] rand_depth();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 24'hFF_FFFF;
         2:       return DEPTH_W'($urandom_range(1, 255));
         default: return DEPTH_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_size();
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom & 32'hFFFF_E000;
      case ($urandom_range(0, 15))
         0:       return junk;
         1:       return junk | 32'd4096;
         2:       return junk | 32'h1FFF;
         3:       return junk | $urandom_range(4097, 8191);
         4, 5:    return junk | $urandom_range(17, 400);
         default: return junk | $urandom_range(1, 16);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_center();
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom & 32'hFFFF_0000;
      case ($urandom_range(0, 3))
         0:       return junk | $urandom_range(0, 255);
         1:       return junk | $urandom_range(0, 16'hFFFF);
         default: return junk | $urandom_range(0, 6400);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_recip();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         default: return 32'hFFFF_FFFF / $urandom_range(100, 2000);
      endcase
   endfunction

   function automatic void queue_reg(logic [CSR_INDEX_W-1:0] index,
      logic [CSR_DATA_W-1:0] data);
      reg_write_type wr;
      wr.index = index;
      wr.data  = data;
      reg_writes.push_back(wr);
   endfunction

   task automatic send_depth(logic [DEPTH_W-1:0] z);
      int gap;
      gap = idle_gap(req_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_depth_z <= z;
      do @(posedge clock); while (!(req_push && !req_full));
   endtask

   task automatic apply_regs();
      while (reg_writes.size() > 0) begin
         csr_valid <= 1'b1;
         csr_index <= reg_writes[0].index;
         csr_wdata <= reg_writes[0].data;
         do @(posedge clock); while (!(csr_valid && csr_ready));
         void'(reg_writes.pop_front());
      end
      csr_valid <= 1'b0;
   endtask

   // stop pushing and wait until every point is out
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (req_push && !req_full) sb.note_depth(req_depth_z);
         if (rsp_pop && !rsp_empty)
            sb.check_point(rsp_point_x, rsp_point_y, rsp_point_z, rsp_frame_end);
      end
   end

   initial begin : drain
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = idle_gap(rsp_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (!(rsp_pop && !rsp_empty));
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("depth_to_point_cloud_tb failed");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int batch;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset setup: zero, tiny, full and mid depths
      send_depth('0);
      send_depth(24'd1);
      send_depth(24'hFF_FFFF);
      send_depth(24'h00_0100);
      send_depth(24'h80_0000);
      settle();

      // one-pixel frames, saturating reciprocals
      queue_reg(CSR_IMAGE_WIDTH, 32'd1);
      queue_reg(CSR_IMAGE_HEIGHT, 32'd1);
      queue_reg(CSR_CENTER_X, 32'd0);
      queue_reg(CSR_CENTER_Y, 32'h0000_FFFF);
      queue_reg(CSR_RECIP_FOCAL_X, 32'hFFFF_FFFF);
      queue_reg(CSR_RECIP_FOCAL_Y, 32'hFFFF_FFFF);
      apply_regs();
      send_depth(24'hFF_FFFF);
      send_depth('0);
      send_depth(24'd1);
      send_depth(24'hAB_CDEF);
      settle();

      // zero sizes, zero reciprocal, writes past the register list
      queue_reg(CSR_IMAGE_WIDTH, 32'hFFFF_E000);
      queue_reg(CSR_IMAGE_HEIGHT, 32'd0);
      queue_reg(CSR_CENTER_X, 32'hFFFF_FFFF);
      queue_reg(CSR_CENTER_Y, 32'd0);
      queue_reg(CSR_RECIP_FOCAL_X, 32'd0);
      queue_reg(CSR_RECIP_FOCAL_Y, 32'd1);
      queue_reg(CSR_SPARE_LO, 32'd3);
      queue_reg(CSR_SPARE_HI, 32'hFFFF_FFFF);
      apply_regs();
      send_depth(24'hFF_FFFF);
      send_depth(24'h12_3456);
      send_depth(24'hFF_FFFF);
      settle();

      // sizes past the maximum
      queue_reg(CSR_IMAGE_WIDTH, 32'h1FFF);
      queue_reg(CSR_IMAGE_HEIGHT, 32'd4097);
      queue_reg(CSR_CENTER_X, 32'd8);
      queue_reg(CSR_RECIP_FOCAL_X, 32'h8000_0000);
      apply_regs();
      send_depth(24'hFF_FFFF);
      send_depth(24'h00_0001);
      send_depth(24'h7F_FFFF);
      send_depth(24'hFF_FFFF);
      settle();

      // 2x3 frames so rows and frames wrap
      queue_reg(CSR_IMAGE_WIDTH, 32'd2);
      queue_reg(CSR_IMAGE_HEIGHT, 32'd3);
      queue_reg(CSR_CENTER_X, 32'd16);
      queue_reg(CSR_CENTER_Y, 32'd16);
      queue_reg(CSR_RECIP_FOCAL_X, 32'd7158278);
      queue_reg(CSR_RECIP_FOCAL_Y, 32'd7158278);
      apply_regs();
      repeat (8) send_depth(rand_depth());
      settle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1)) queue_reg(CSR_IMAGE_WIDTH, rand_size());
         if ($urandom_range(0, 1)) queue_reg(CSR_IMAGE_HEIGHT, rand_size());
         if ($urandom_range(0, 1)) queue_reg(CSR_CENTER_X, rand_center());
         if ($urandom_range(0, 1)) queue_reg(CSR_CENTER_Y, rand_center());
         if ($urandom_range(0, 1)) queue_reg(CSR_RECIP_FOCAL_X, rand_recip());
         if ($urandom_range(0, 1)) queue_reg(CSR_RECIP_FOCAL_Y, rand_recip());
         if ($urandom_range(0, 7) == 0)
            queue_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
         apply_regs();
         batch = $urandom_range(20, 150);
         repeat (batch) send_depth(rand_depth());
         sent += batch;
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("depth_to_point_cloud_tb passed");
      end else begin
         $display("depth_to_point_cloud_tb failed");
      end
      $finish;
   end

endmodule
